>>> hdl/rcem_pkg.sv
// Roberts cross edge magnitude: shared constants, types and helper functions.
// No dependencies; imported by roberts_cross_edge_magnitude.
`timescale 1ns / 1ps

package rcem_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 16;
    localparam int PIX_W     = 8;
    localparam int CFG_FW_W  = 12;
    localparam int CFG_FH_W  = 16;
    localparam int CFG_DW    = 16;
    localparam int SUM_W     = 17;
    localparam int ROOT_W    = 9;
    localparam int SQ_STEPS  = ROOT_W;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } t_meta;

    typedef struct packed {
        logic [SUM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // one bit of the root: rem tracks v - root^2
    function automatic t_sq sqrt_step(input t_sq s, input logic [3:0] k);
        logic [SUM_W+1:0] term;
        t_sq              r;
        r    = s;
        term = ((SUM_W+2)'(s.root) << (k + 4'd1)) + ((SUM_W+2)'(1) << (5'(k) * 5'd2));
        if ({2'b00, s.rem} >= term) begin
            r.rem     = s.rem - term[SUM_W-1:0];
            r.root[k] = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> hdl/roberts_cross_edge_magnitude.sv
// Roberts cross edge magnitude over a raster-order grey pixel stream.
// Depends on rcem_pkg (constants, window meta and root step types).
//
// Usage:
//   Input channel: i_valid / i_pixel, o_stall. One pixel word per accepted
//   handshake, raster order, frame size from the two configuration registers
//   (i_cfg_we, i_cfg_index, i_cfg_data; write only, reset 2048 x 2048).
//   Output channel: o_valid / o_edge_value, o_out_row, o_out_col,
//   o_frame_last, i_stall. One word for every pixel at row >= 1, col >= 1,
//   giving the window whose top-left is (row-1, col-1); none for the first
//   row or column. o_frame_last marks the frame's final word.
//   Throughput: one pixel per cycle while the output is not stalled. The
//   previous row lives in a 2048 x 8 synchronous line store, read when a
//   pixel enters and written back from the entry registers; the magnitude
//   runs through a nine-stage bit-per-stage root pipeline.
//   Path: entry registers, sum register, root stages, output register.
//   Stall: the pipeline advances as one; while a result waits under
//   i_stall, o_stall is high and nothing moves.
//   Reset: counters return to the frame origin, pipeline empties. The line
//   store is not cleared; it is filled by the first row of each frame.
`timescale 1ns / 1ps

module roberts_cross_edge_magnitude (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [rcem_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                         i_valid,
    input  logic [rcem_pkg::PIX_W-1:0]   i_pixel,
    output logic                         o_stall,
    output logic                         o_valid,
    output logic [rcem_pkg::PIX_W-1:0]   o_edge_value,
    output logic [rcem_pkg::ROW_W-1:0]   o_out_row,
    output logic [rcem_pkg::COL_W-1:0]   o_out_col,
    output logic                         o_frame_last,
    input  logic                         i_stall
);
    import rcem_pkg::*;

    logic [CFG_FW_W-1:0] r_frame_width;
    logic [CFG_FH_W-1:0] r_frame_height;
    logic [CFG_FW_W-1:0] n_width;
    logic [CFG_FH_W:0]   n_height;

    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic                n_en;
    logic                n_accept;
    logic                n_row_end;
    logic                n_frame_end;
    logic                n_emit;

    logic [PIX_W-1:0]    r_row_store [MAX_WIDTH];
    logic [PIX_W-1:0]    r_above;
    logic [PIX_W-1:0]    r_left;
    logic [PIX_W-1:0]    r_upleft;

    logic                r_s1_valid;
    logic                r_s1_emit;
    logic [PIX_W-1:0]    r_s1_pix;
    logic [COL_W-1:0]    r_s1_col;
    t_meta               r_s1_meta;

    logic                r_s2_valid;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [PIX_W-1:0]    n_dh;
    logic [PIX_W-1:0]    n_dv;
    t_meta               r_s2_meta;

    t_sq                 r_q      [SQ_STEPS];
    t_meta               r_q_meta [SQ_STEPS];
    logic [SQ_STEPS-1:0] r_q_valid;

    logic                r_out_valid;
    logic [PIX_W-1:0]    r_edge;
    t_meta               r_out_meta;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_FW_W'(MAX_WIDTH);
            r_frame_height <= CFG_FH_W'(2048);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[CFG_FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[CFG_FH_W-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width < CFG_FW_W'(2)) begin
            n_width = CFG_FW_W'(2);
        end else if (r_frame_width > CFG_FW_W'(MAX_WIDTH)) begin
            n_width = CFG_FW_W'(MAX_WIDTH);
        end else begin
            n_width = r_frame_width;
        end
        if (r_frame_height < CFG_FH_W'(2)) begin
            n_height = (CFG_FH_W+1)'(2);
        end else begin
            n_height = {1'b0, r_frame_height};
        end
    end

    assign n_en        = !(r_out_valid && i_stall);
    assign o_stall     = !n_en;
    assign n_accept    = i_valid && n_en;
    assign n_row_end   = ({1'b0, r_col} + CFG_FW_W'(1)) >= n_width;
    assign n_frame_end = n_row_end && (({1'b0, r_row} + (ROW_W+1)'(1)) >= n_height);
    assign n_emit      = (r_row != '0) && (r_col != '0);

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (n_accept) begin
            if (n_row_end) begin
                r_col <= '0;
                r_row <= n_frame_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // line store: read on entry, write back from the entry registers
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_above <= r_row_store[r_col];
            if (r_s1_valid) begin
                r_row_store[r_s1_col] <= r_s1_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_upleft <= '0;
        end else if (n_en && r_s1_valid) begin
            r_left   <= r_s1_pix;
            r_upleft <= r_above;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_s1_emit      <= n_emit;
            r_s1_pix       <= i_pixel;
            r_s1_col       <= r_col;
            r_s1_meta.row  <= r_row - ROW_W'(1);
            r_s1_meta.col  <= r_col - COL_W'(1);
            r_s1_meta.last <= n_frame_end;
        end
    end

    // window sum of squares
    assign n_dh  = abs_diff(r_upleft, r_s1_pix);
    assign n_dv  = abs_diff(r_above, r_left);
    assign n_sum = SUM_W'({8'd0, n_dh} * {8'd0, n_dh}) + SUM_W'({8'd0, n_dv} * {8'd0, n_dv});

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sum     <= n_sum;
            r_s2_meta <= r_s1_meta;
        end
    end

    // root pipeline, one result bit per stage
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_q[0]      <= sqrt_step(t_sq'{rem: r_sum, root: '0}, 4'(SQ_STEPS-1));
            r_q_meta[0] <= r_s2_meta;
            for (int j = 1; j < SQ_STEPS; j++) begin
                r_q[j]      <= sqrt_step(r_q[j-1], 4'(SQ_STEPS-1-j));
                r_q_meta[j] <= r_q_meta[j-1];
            end
            r_edge     <= (r_q[SQ_STEPS-1].root > ROOT_W'(255)) ?
                          PIX_W'(255) : r_q[SQ_STEPS-1].root[PIX_W-1:0];
            r_out_meta <= r_q_meta[SQ_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_q_valid   <= '0;
            r_out_valid <= 1'b0;
        end else if (n_en) begin
            r_s1_valid  <= n_accept;
            r_s2_valid  <= r_s1_valid && r_s1_emit;
            r_q_valid   <= {r_q_valid[SQ_STEPS-2:0], r_s2_valid};
            r_out_valid <= r_q_valid[SQ_STEPS-1];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_value = r_edge;
    assign o_out_row    = r_out_meta.row;
    assign o_out_col    = r_out_meta.col;
    assign o_frame_last = r_out_meta.last;

`ifndef SYNTHESIS
    // write-back never targets the entry being read by the entering pixel
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_accept && r_s1_valid) |-> (r_col != r_s1_col))
        else $error("line store read and write collide");

    a_emit_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_emit) |-> (r_s1_col != '0))
        else $error("result raised for a first-column pixel");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_q_valid[SQ_STEPS-1]))
        else $error("output word without a finished root");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_q_valid) && $stable(r_s2_valid))
        else $error("pipeline moved while output stalled");
`endif

endmodule
